// ===== hw/rtl/ccmf_pkg.sv =====
// ----------------------------------------------------------------------------
// ccmf_pkg: shared definitions for the cluster correspondence match filter
// Holds sizes, request mode codes, state codes and small helper functions.
// ----------------------------------------------------------------------------
package ccmf_pkg;

   localparam int MAX_CLUSTERS = 16;
   localparam int LBL_BITS     = $clog2(MAX_CLUSTERS);
   localparam int NCL_BITS     = LBL_BITS + 1;
   localparam int CELLS        = MAX_CLUSTERS * MAX_CLUSTERS;
   localparam int ADDR_BITS    = 2 * LBL_BITS;
   localparam int COUNT_BITS   = 13;
   localparam int PCT_SCALE    = 100;
   localparam int PCT_BITS     = 7;
   localparam int NUM_BITS     = COUNT_BITS + PCT_BITS;
   localparam int STEP_BITS    = $clog2(NUM_BITS + 1);

   typedef logic [2:0]             mode_type;
   typedef logic signed [4:0]      label_type;
   typedef logic [COUNT_BITS-1:0]  count_type;
   typedef logic [NUM_BITS-1:0]    quot_type;
   typedef logic [ADDR_BITS-1:0]   addr_type;

   // Request modes.
   localparam mode_type MODE_CLEAR    = 3'd0;
   localparam mode_type MODE_SIZE     = 3'd1;
   localparam mode_type MODE_MATCH    = 3'd2;
   localparam mode_type MODE_COMPUTE  = 3'd3;
   localparam mode_type MODE_CLASSIFY = 3'd4;

   // Controller states.
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_INC  = 5'b00010,
      ST_SCAN = 5'b00100,
      ST_CELL = 5'b01000,
      ST_DIV  = 5'b10000
   } state_type;

   // Divider control handed from the controller.
   typedef struct packed {
      logic      start;
      quot_type  num;
      count_type den;
   } div_req_type;

   // A label is usable when it is not noise and is inside the table.
   function automatic logic label_ok(input label_type l);
      label_ok = !l[4] && (32'(l[3:0]) < MAX_CLUSTERS);
   endfunction

   // Saturating counter increment.
   function automatic count_type sat_inc(input count_type c);
      sat_inc = (c == {COUNT_BITS{1'b1}}) ? c : c + 1'b1;
   endfunction

endpackage

// ===== hw/rtl/cluster_correspondence_match_filter.sv =====
// ----------------------------------------------------------------------------
// cluster_correspondence_match_filter: keypoint cluster correspondence filter
// Counts cluster sizes and co-occurrences, pairs clusters greedily by
// percentage and classifies match pairs against that pairing.
// ----------------------------------------------------------------------------
//  Channel  Direction  Signals
//  req_     in         req_valid, req_ready, req_mode, req_label_a, req_label_b
//  rsp_     out        rsp_valid, rsp_ready, rsp_keep, rsp_pair_count
//
// Clear, size and classify requests complete as they are accepted; a match request
// reads the count memory and writes the incremented count back. Compute walks each
// row over the free columns, running the divider for a column whose cluster size is
// nonzero.
// Reset is synchronous and acts like a clear request, with no sweep needed.
// A request is taken only while idle with the result register free or draining.
// ----------------------------------------------------------------------------
module cluster_correspondence_match_filter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ccmf_pkg::mode_type   req_mode,
   input  ccmf_pkg::label_type  req_label_a,
   input  ccmf_pkg::label_type  req_label_b,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_keep,
   output logic [4:0]           rsp_pair_count
);
   import ccmf_pkg::*;

   state_type               st_ff, st_in;
   count_type               size_ff [MAX_CLUSTERS];
   label_type               max1_ff, max2_ff;
   logic [LBL_BITS-1:0]     partner_ff [MAX_CLUSTERS];
   logic [MAX_CLUSTERS-1:0] used_ff;
   logic                    rows1_ff;
   logic [NCL_BITS-1:0]     paired_ff, nr_ff, nc_ff, row_ff, col_ff;
   logic [LBL_BITS-1:0]     best_ff;
   quot_type                best_v_ff;
   logic                    best_ok_ff;
   addr_type                inc_addr_ff;
   logic                    rsp_valid_ff;
   logic                    keep_ff;
   logic [4:0]              pcnt_ff;

   logic                    accept;
   logic [NCL_BITS-1:0]     n1, n2;
   logic [LBL_BITS-1:0]     ri, ci, i1, i2;
   label_type               crow, ccol;
   logic                    rd_en, wr_en;
   addr_type                rd_addr;
   count_type               rd_data, wr_data;
   count_type               cur_size;
   div_req_type             div_req;
   logic                    div_done;
   quot_type                div_quot, cand_v;
   logic                    take;

   assign accept    = req_valid && req_ready;
   assign req_ready = (st_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);

   // Cluster counts and the current cell in matrix coordinates.
   assign n1       = NCL_BITS'(max1_ff + 5'sd1);
   assign n2       = NCL_BITS'(max2_ff + 5'sd1);
   assign ri       = row_ff[LBL_BITS-1:0];
   assign ci       = col_ff[LBL_BITS-1:0];
   assign i1       = rows1_ff ? ri : ci;
   assign i2       = rows1_ff ? ci : ri;
   assign cur_size = size_ff[i2];

   // Count memory port selection.
   assign rd_en   = (accept && req_mode == MODE_MATCH) ||
                    (st_ff == ST_SCAN && col_ff != nc_ff && !used_ff[ci]);
   assign rd_addr = (st_ff == ST_IDLE) ? {req_label_a[LBL_BITS-1:0], req_label_b[LBL_BITS-1:0]}
                                       : {i1, i2};
   assign wr_en   = (st_ff == ST_INC);
   assign wr_data = sat_inc(rd_data);

   ccmf_cooc_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .clr     (accept && req_mode == MODE_CLEAR),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (inc_addr_ff),
      .wr_data (wr_data)
   );

   // Percentage = count * 100 / size, through the divider.
   always_comb begin
      div_req.start = (st_ff == ST_CELL) && (cur_size != '0);
      div_req.num   = NUM_BITS'(rd_data) * NUM_BITS'(PCT_SCALE);
      div_req.den   = cur_size;
   end

   ccmf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Best-candidate comparison for the cell just evaluated.
   assign cand_v = (st_ff == ST_CELL) ? '0 : div_quot;
   assign take   = !best_ok_ff || (cand_v > best_v_ff);

   // Classify row and column in the current orientation.
   assign crow = rows1_ff ? req_label_a : req_label_b;
   assign ccol = rows1_ff ? req_label_b : req_label_a;

   // Next state.
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_MATCH && label_ok(req_label_a) &&
                   label_ok(req_label_b)) begin
                  st_in = ST_INC;
               end else if (req_mode == MODE_COMPUTE &&
                            ((n1 <= n2) ? n1 : n2) != '0) begin
                  st_in = ST_SCAN;
               end
            end
         end
         ST_INC:  st_in = ST_IDLE;
         ST_SCAN: begin
            if (col_ff == nc_ff) begin
               if (row_ff + 1'b1 == nr_ff) begin
                  st_in = ST_IDLE;
               end
            end else if (!used_ff[ci]) begin
               st_in = ST_CELL;
            end
         end
         ST_CELL: st_in = (cur_size != '0) ? ST_DIV : ST_SCAN;
         ST_DIV:  st_in = div_done ? ST_SCAN : ST_DIV;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   // Label statistics and pairing state.
   always_ff @(posedge clock) begin
      if (reset || (accept && req_mode == MODE_CLEAR)) begin
         for (int i = 0; i < MAX_CLUSTERS; i++) begin
            size_ff[i] <= '0;
         end
         max1_ff   <= -5'sd1;
         max2_ff   <= -5'sd1;
         used_ff   <= '0;
         rows1_ff  <= 1'b1;
         paired_ff <= '0;
      end else begin
         if (accept && req_mode == MODE_SIZE && label_ok(req_label_b)) begin
            size_ff[req_label_b[LBL_BITS-1:0]] <= sat_inc(size_ff[req_label_b[LBL_BITS-1:0]]);
            if (req_label_b > max2_ff) begin
               max2_ff <= req_label_b;
            end
         end
         if (accept && req_mode == MODE_MATCH && label_ok(req_label_a) &&
             req_label_a > max1_ff) begin
            max1_ff <= req_label_a;
         end
         if (accept && req_mode == MODE_COMPUTE) begin
            rows1_ff <= (n1 <= n2);
            used_ff  <= '0;
            if (((n1 <= n2) ? n1 : n2) == '0) begin
               paired_ff <= '0;
            end
         end
         if (st_ff == ST_SCAN && col_ff == nc_ff) begin
            used_ff[best_ok_ff ? best_ff : '0] <= 1'b1;
            if (row_ff + 1'b1 == nr_ff) begin
               paired_ff <= nr_ff;
            end
         end
      end
   end

   // Walk counters and best-candidate tracking.
   always_ff @(posedge clock) begin
      if (accept && req_mode == MODE_COMPUTE) begin
         nr_ff      <= (n1 <= n2) ? n1 : n2;
         nc_ff      <= (n1 <= n2) ? n2 : n1;
         row_ff     <= '0;
         col_ff     <= '0;
         best_ok_ff <= 1'b0;
      end
      if (accept) begin
         inc_addr_ff <= rd_addr;
      end
      case (st_ff)
         ST_SCAN: begin
            if (col_ff == nc_ff) begin
               partner_ff[ri] <= best_ok_ff ? best_ff : '0;
               row_ff         <= row_ff + 1'b1;
               col_ff         <= '0;
               best_ok_ff     <= 1'b0;
            end else if (used_ff[ci]) begin
               col_ff <= col_ff + 1'b1;
            end
         end
         ST_CELL: begin
            if (cur_size == '0) begin
               if (take) begin
                  best_ff    <= ci;
                  best_v_ff  <= cand_v;
                  best_ok_ff <= 1'b1;
               end
               col_ff <= col_ff + 1'b1;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (take) begin
                  best_ff    <= ci;
                  best_v_ff  <= cand_v;
                  best_ok_ff <= 1'b1;
               end
               col_ff <= col_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept && req_mode == MODE_CLASSIFY) begin
            rsp_valid_ff <= 1'b1;
            keep_ff      <= label_ok(crow) && label_ok(ccol) &&
                            (NCL_BITS'(crow[LBL_BITS-1:0]) < paired_ff) &&
                            (partner_ff[crow[LBL_BITS-1:0]] == ccol[LBL_BITS-1:0]);
            pcnt_ff      <= '0;
         end else if (accept && req_mode == MODE_COMPUTE &&
                      ((n1 <= n2) ? n1 : n2) == '0) begin
            rsp_valid_ff <= 1'b1;
            keep_ff      <= 1'b0;
            pcnt_ff      <= '0;
         end else if (st_ff == ST_SCAN && col_ff == nc_ff && row_ff + 1'b1 == nr_ff) begin
            rsp_valid_ff <= 1'b1;
            keep_ff      <= 1'b0;
            pcnt_ff      <= 5'(nr_ff);
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_keep       = keep_ff;
   assign rsp_pair_count = pcnt_ff;

endmodule

// ===== hw/rtl/ccmf_cooc_ram.sv =====
// ----------------------------------------------------------------------------
// ccmf_cooc_ram: co-occurrence count memory
// One write and one registered read port; per-entry valid flops make a clear
// take effect at once, and an entry that is not valid reads as zero.
// ----------------------------------------------------------------------------
module ccmf_cooc_ram (
   input  logic               clock,
   input  logic               reset,
   input  logic               clr,
   input  logic               rd_en,
   input  ccmf_pkg::addr_type  rd_addr,
   output ccmf_pkg::count_type rd_data,
   input  logic               wr_en,
   input  ccmf_pkg::addr_type  wr_addr,
   input  ccmf_pkg::count_type wr_data
);
   import ccmf_pkg::*;

   count_type           mem [CELLS];
   logic [CELLS-1:0]    vld_ff;
   count_type           rd_data_ff;
   logic                rd_vld_ff;

   // Storage array and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Valid flags, cleared all together.
   always_ff @(posedge clock) begin
      if (reset || clr) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

// ===== hw/rtl/ccmf_div.sv =====
// ----------------------------------------------------------------------------
// ccmf_div: restoring divider
// Produces one quotient bit per cycle; done pulses with the quotient.
// ----------------------------------------------------------------------------
module ccmf_div (
   input  logic                  clock,
   input  logic                  reset,
   input  ccmf_pkg::div_req_type req,
   output logic                  done,
   output ccmf_pkg::quot_type     quot
);
   import ccmf_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   count_type             rem_ff, rem_in;
   quot_type              quo_ff, quo_in;
   count_type             den_ff, den_in;
   logic [COUNT_BITS:0]   trial;
   logic                  fits;

   // One shift-subtract step.
   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_BITS-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = req.num;
         den_in  = req.den;
      end else if (busy_ff) begin
         rem_in  = fits ? COUNT_BITS'(trial - {1'b0, den_ff}) : trial[COUNT_BITS-1:0];
         quo_in  = {quo_ff[NUM_BITS-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_BITS'(NUM_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule
